/* src/swif_pkg.sv */
package swif_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W   = 8;
  localparam int SIZE_W  = 11;
  localparam int COORD_W = 10;
  localparam int MODE_W  = 3;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = COL_W;
  localparam int CMP_W   = ((COL_W > ROW_W) ? COL_W : ROW_W) + SIZE_W;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_MODE  = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  localparam logic [MODE_W-1:0] MODE_BLUR     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ROBERTS  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MEDIAN   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EROSION  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DILATION = 3'd4;
  localparam logic [MODE_W-1:0] MODE_GRADIENT = 3'd5;

  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  typedef struct packed {
    logic               emit;
    logic [PIX_W-1:0]   value;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } result_t;

endpackage

/* src/swif_line_buf.sv */
module swif_line_buf
  import swif_pkg::*;
(
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_a,
  input  logic [PIX_W-1:0]  wr_b,
  output logic [PIX_W-1:0]  rd_a,
  output logic [PIX_W-1:0]  rd_b
);

  logic [PIX_W-1:0] mem_a [MAX_WIDTH];
  logic [PIX_W-1:0] mem_b [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_a;
      mem_b[wr_addr] <= wr_b;
    end
    if (rd_en) begin
      rd_a <= mem_a[rd_addr];
      rd_b <= mem_b[rd_addr];
    end
  end

endmodule

/* src/swif_filter.sv */
module swif_filter
  import swif_pkg::*;
(
  input  window_t           win,
  input  logic [MODE_W-1:0] mode,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  col,
  output result_t           res
);

  logic [PIX_W-1:0] up, lf, ce, rt, dn;
  logic [PIX_W-1:0] mn, mx;
  logic [PIX_W-1:0] ma, mb, md, med_mx, med_mn;
  logic [PIX_W+3:0] blur_sum;
  logic [PIX_W:0]   rob_sum;
  logic [PIX_W-1:0] d0, d1;
  logic [PIX_W+1:0] med_sum;
  logic             r_ge1, r_ge2, c_ge1, c_ge2;
  logic [ROW_W-1:0] row_m1;
  logic [COL_W-1:0] col_m1;

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  always_comb begin
    up = win[0][1];
    lf = win[1][0];
    ce = win[1][1];
    rt = win[1][2];
    dn = win[2][1];
    mn = min2(min2(min2(up, lf), min2(ce, rt)), dn);
    mx = max2(max2(max2(up, lf), max2(ce, rt)), dn);

    blur_sum = {4'd0, win[0][0]} + {3'd0, win[0][1], 1'b0} + {4'd0, win[0][2]}
             + {3'd0, win[1][0], 1'b0} + {2'd0, win[1][1], 2'b0} + {3'd0, win[1][2], 1'b0}
             + {4'd0, win[2][0]} + {3'd0, win[2][1], 1'b0} + {4'd0, win[2][2]};

    d0 = (win[1][1] > win[2][2]) ? win[1][1] - win[2][2] : win[2][2] - win[1][1];
    d1 = (win[1][2] > win[2][1]) ? win[1][2] - win[2][1] : win[2][1] - win[1][2];
    rob_sum = {1'b0, d0} + {1'b0, d1};

    ma = win[2][0];
    mb = win[2][1];
    md = win[2][2];
    med_mx = max2(max2(ma, mb), md);
    med_mn = min2(min2(ma, mb), md);
    med_sum = {2'd0, ma} + {2'd0, mb} + {2'd0, md} - {2'd0, med_mx} - {2'd0, med_mn};

    r_ge1 = (row >= ROW_W'(1));
    r_ge2 = (row >= ROW_W'(2));
    c_ge1 = (col >= COL_W'(1));
    c_ge2 = (col >= COL_W'(2));
    row_m1 = row - ROW_W'(1);
    col_m1 = col - COL_W'(1);

    res.emit  = 1'b0;
    res.value = '0;
    res.row   = COORD_W'(row_m1);
    res.col   = COORD_W'(col_m1);
    case (mode)
      MODE_BLUR: begin
        res.emit  = r_ge2 && c_ge2;
        res.value = blur_sum[PIX_W+3:4];
      end
      MODE_EROSION: begin
        res.emit  = r_ge2 && c_ge2;
        res.value = mn;
      end
      MODE_DILATION: begin
        res.emit  = r_ge2 && c_ge2;
        res.value = mx;
      end
      MODE_GRADIENT: begin
        res.emit  = r_ge2 && c_ge2;
        res.value = mx - mn;
      end
      MODE_ROBERTS: begin
        res.emit  = r_ge1 && c_ge1;
        res.value = rob_sum[PIX_W] ? {PIX_W{1'b1}} : rob_sum[PIX_W-1:0];
      end
      MODE_MEDIAN: begin
        res.emit  = c_ge2;
        res.value = med_sum[PIX_W-1:0];
        res.row   = COORD_W'(row);
      end
      default: begin
        res.emit = 1'b0;
      end
    endcase
  end

endmodule

/* src/selectable_window_image_filter_unit.sv */
// 3x3 window image filter for 8-bit grey pixels in raster order.
// input stream s_*: s_tdata[7:0] is one source pixel; one per cycle if s_tready.
// output stream m_*: m_tdata carries the filtered pixel and its row and column,
// m_tlast marks the result caused by the final pixel of the frame.
// config channel cfg_*: index 0 filter mode, 1 image width, 2 image height;
// always ready, write only while no pixel is in flight.
// border positions produce no result, so a frame gives fewer results than
// pixels; which pixel produces which result depends on the mode.
// an accepted pixel is held in the middle stage; its result is registered onto m_*.
// throughput: one pixel per cycle unless m_tready stalls; the line store read at
// acceptance and write-back of the previous pixel use separate read/write ports.
// s_tready stays high while the output register is free or being drained; when
// the receiver holds m_tready low, one pixel waits in the middle stage and then
// s_tready drops until the result is taken.
// reset clears the counters, window and config (mode blur, 1024 x 1024); the
// line stores are not cleared, so the first two rows of a frame fill them.
module selectable_window_image_filter_unit
  import swif_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,   // pixel_in
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_out, out_row, out_col, zero pad
  output logic                  m_tlast,   // frame_last
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data
);

  logic [MODE_W-1:0] filter_mode;
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic [CMP_W-1:0]  w_eff, h_eff;

  logic [ROW_W-1:0] row_count, row_count_next;
  logic [COL_W-1:0] col_count, col_count_next;
  logic             last_in;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_px;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic             s1_last;

  logic [PIX_W-1:0] rd_a, rd_b;
  window_t          window, window_next;
  result_t          res;

  logic             accept, adv;
  logic [PIX_W-1:0]   o_px;
  logic [COORD_W-1:0] o_row, o_col;

  assign cfg_ready = 1'b1;
  assign adv       = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s1_valid || adv;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    if (image_width < SIZE_W'(3)) begin
      w_eff = CMP_W'(3);
    end else if (CMP_W'(image_width) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(image_width);
    end
    if (image_height < SIZE_W'(3)) begin
      h_eff = CMP_W'(3);
    end else if (CMP_W'(image_height) > CMP_W'(MAX_HEIGHT)) begin
      h_eff = CMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = CMP_W'(image_height);
    end
  end

  always_comb begin
    logic c_end, r_end;
    c_end = (CMP_W'(col_count) + CMP_W'(1)) >= w_eff;
    r_end = (CMP_W'(row_count) + CMP_W'(1)) >= h_eff;
    last_in = c_end && r_end;
    if (c_end) begin
      col_count_next = '0;
      row_count_next = r_end ? '0 : row_count + ROW_W'(1);
    end else begin
      col_count_next = col_count + COL_W'(1);
      row_count_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= MODE_BLUR;
      image_width  <= SIZE_W'(1024);
      image_height <= SIZE_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FILTER_MODE:  filter_mode  <= cfg_data[MODE_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      if (accept) begin
        row_count <= row_count_next;
        col_count <= col_count_next;
        s1_valid  <= 1'b1;
      end else if (adv) begin
        s1_valid  <= 1'b0;
      end
    end
    if (accept) begin
      s1_px   <= s_tdata;
      s1_row  <= row_count;
      s1_col  <= col_count;
      s1_last <= last_in;
    end
  end

  swif_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (ADDR_W'(col_count)),
    .wr_en   (adv),
    .wr_addr (ADDR_W'(s1_col)),
    .wr_a    (s1_px),
    .wr_b    (rd_a),
    .rd_a    (rd_a),
    .rd_b    (rd_b)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      window_next[k][0] = window[k][1];
      window_next[k][1] = window[k][2];
    end
    window_next[0][2] = rd_b;
    window_next[1][2] = rd_a;
    window_next[2][2] = s1_px;
  end

  swif_filter u_filter (
    .win  (window_next),
    .mode (filter_mode),
    .row  (s1_row),
    .col  (s1_col),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        window <= window_next;
      end
      if (adv && res.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (adv && res.emit) begin
      o_px    <= res.value;
      o_row   <= res.row;
      o_col   <= res.col;
      m_tlast <= s1_last;
    end
  end

  assign m_tdata = {(OUT_DATA_W - PIX_W - 2 * COORD_W)'(0), o_col, o_row, o_px};

endmodule
